// ----- design/grcw_pkg.sv -----
// Shared defaults for the grid ray cell walker.
package grcw_pkg;

    localparam int GRID_BITS_DEF = 5;
    localparam int FRAC_BITS_DEF = 10;

endpackage

// ----- design/grcw_axis_setup.sv -----
// Per-axis setup: extent, first-crossing numerator, direction and cell span.
module grcw_axis_setup
    import grcw_pkg::*;
#(
    parameter int GRID_BITS = GRID_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int POS_W    = GRID_BITS + FRAC_BITS,
    localparam int NUM_W    = POS_W + 1
) (
    input  logic [POS_W-1:0]     pos_start,
    input  logic [POS_W-1:0]     pos_end,
    output logic [POS_W-1:0]     extent,
    output logic [NUM_W-1:0]     numer,
    output logic                 moves,
    output logic                 neg,
    output logic [GRID_BITS-1:0] span
);

    logic [FRAC_BITS-1:0]  frac_s;
    logic [GRID_BITS-1:0]  cell_s;
    logic [GRID_BITS-1:0]  cell_e;
    logic [FRAC_BITS:0]    cell_one;

    assign frac_s   = pos_start[FRAC_BITS-1:0];
    assign cell_s   = pos_start[POS_W-1:FRAC_BITS];
    assign cell_e   = pos_end[POS_W-1:FRAC_BITS];
    assign cell_one = {1'b1, {FRAC_BITS{1'b0}}};

    always_comb begin
        extent = '0;
        numer  = '0;
        moves  = 1'b0;
        neg    = 1'b0;
        span   = '0;
        if (pos_end > pos_start) begin
            extent = pos_end - pos_start;
            numer  = {{(NUM_W-FRAC_BITS-1){1'b0}}, cell_one - {1'b0, frac_s}};
            moves  = 1'b1;
            span   = cell_e - cell_s;
        end else if (pos_end < pos_start) begin
            extent = pos_start - pos_end;
            // on a boundary the distance is zero, so this axis steps first
            numer  = {{(NUM_W-FRAC_BITS){1'b0}}, frac_s};
            moves  = 1'b1;
            neg    = 1'b1;
            span   = cell_s - cell_e;
        end
    end

endmodule

// ----- design/grcw_mul_unit.sv -----
// Shared multiplier with operand select and registered product.
module grcw_mul_unit
    import grcw_pkg::*;
#(
    parameter int A_W = GRID_BITS_DEF + FRAC_BITS_DEF + 1,
    parameter int B_W = GRID_BITS_DEF + FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               sel,
    input  logic [A_W-1:0]     a0,
    input  logic [B_W-1:0]     b0,
    input  logic [A_W-1:0]     a1,
    input  logic [B_W-1:0]     b1,
    output logic [A_W+B_W-1:0] prod
);

    logic [A_W-1:0]     op_a;
    logic [B_W-1:0]     op_b;
    logic [A_W+B_W-1:0] prod_reg;

    assign op_a = sel ? a1 : a0;
    assign op_b = sel ? b1 : b0;

    always_ff @(posedge aclk) begin
        prod_reg <= {{B_W{1'b0}}, op_a} * {{A_W{1'b0}}, op_b};
    end

    assign prod = prod_reg;

endmodule

// ----- design/grid_ray_cell_walker.sv -----
// Top level: 2D grid ray traversal, one visited cell per output transaction.
// After a segment is accepted, the sequencer runs setup, two multiply states and a load state before the first cell.
// A new segment is taken only in idle, after the last cell of the previous one is taken;
// setup runs two products through one shared multiplier, then one cell per cycle while m_tready is high.
// Walk steps use add and compare on the registered cross products.
// Reset: aresetn (synchronous, active low) clears sequencer, counters and valids.
module grid_ray_cell_walker
    import grcw_pkg::*;
#(
    parameter int GRID_BITS = GRID_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int POS_W    = GRID_BITS + FRAC_BITS,
    localparam int NUM_W    = POS_W + 1,
    localparam int PROD_W   = POS_W + NUM_W,
    localparam int CNT_W    = GRID_BITS + 1,
    localparam int S_W      = ((4 * POS_W + 7) / 8) * 8,
    localparam int M_W      = ((2 * GRID_BITS + 7) / 8) * 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    // start_x, start_y, end_x, end_y (POS_W bits each), zero padding
    input  logic [S_W-1:0] s_tdata,
    output logic           m_tvalid,
    input  logic           m_tready,
    // cell_x, cell_y (GRID_BITS bits each), zero padding
    output logic [M_W-1:0] m_tdata,
    output logic           m_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MULX,
        ST_MULY,
        ST_LOAD,
        ST_EMIT
    } state_t;

    state_t state_reg;

    logic [POS_W-1:0]     sx_reg, sy_reg, ex_reg, ey_reg;
    logic [POS_W-1:0]     dx_reg, dy_reg;
    logic [NUM_W-1:0]     nx_reg, ny_reg;
    logic                 x_mv_reg, y_mv_reg, x_neg_reg, y_neg_reg;
    logic [GRID_BITS-1:0] cx_reg, cy_reg;
    logic [CNT_W-1:0]     steps_reg;
    logic [PROD_W-1:0]    px_reg, py_reg;
    logic                 m_tvalid_reg;

    logic [POS_W-1:0]     ax_ext, ay_ext;
    logic [NUM_W-1:0]     ax_num, ay_num;
    logic                 ax_mv, ay_mv, ax_neg, ay_neg;
    logic [GRID_BITS-1:0] ax_span, ay_span;
    logic [PROD_W-1:0]    mul_q;
    logic                 step_y;
    logic [PROD_W-1:0]    inc_x, inc_y;

    grcw_axis_setup #(.GRID_BITS(GRID_BITS), .FRAC_BITS(FRAC_BITS)) u_axis_x (
        .pos_start (sx_reg),
        .pos_end   (ex_reg),
        .extent    (ax_ext),
        .numer     (ax_num),
        .moves     (ax_mv),
        .neg       (ax_neg),
        .span      (ax_span)
    );

    grcw_axis_setup #(.GRID_BITS(GRID_BITS), .FRAC_BITS(FRAC_BITS)) u_axis_y (
        .pos_start (sy_reg),
        .pos_end   (ey_reg),
        .extent    (ay_ext),
        .numer     (ay_num),
        .moves     (ay_mv),
        .neg       (ay_neg),
        .span      (ay_span)
    );

    // px = nx * dy first, then py = ny * dx
    grcw_mul_unit #(.A_W(NUM_W), .B_W(POS_W)) u_mul (
        .aclk (aclk),
        .sel  (state_reg == ST_MULY),
        .a0   (nx_reg),
        .b0   (dy_reg),
        .a1   (ny_reg),
        .b1   (dx_reg),
        .prod (mul_q)
    );

    // ties go to x; a zero-extent axis never steps
    always_comb begin
        if (!x_mv_reg) begin
            step_y = 1'b1;
        end else if (!y_mv_reg) begin
            step_y = 1'b0;
        end else begin
            step_y = py_reg < px_reg;
        end
    end

    // one cell of progress adds CELL_ONE * extent of the other axis
    assign inc_x = {{(PROD_W-POS_W-FRAC_BITS){1'b0}}, dy_reg, {FRAC_BITS{1'b0}}};
    assign inc_y = {{(PROD_W-POS_W-FRAC_BITS){1'b0}}, dx_reg, {FRAC_BITS{1'b0}}};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            steps_reg    <= '0;
            cx_reg       <= '0;
            cy_reg       <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        sx_reg    <= s_tdata[POS_W-1:0];
                        sy_reg    <= s_tdata[2*POS_W-1:POS_W];
                        ex_reg    <= s_tdata[3*POS_W-1:2*POS_W];
                        ey_reg    <= s_tdata[4*POS_W-1:3*POS_W];
                        state_reg <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    dx_reg    <= ax_ext;
                    dy_reg    <= ay_ext;
                    nx_reg    <= ax_num;
                    ny_reg    <= ay_num;
                    x_mv_reg  <= ax_mv;
                    y_mv_reg  <= ay_mv;
                    x_neg_reg <= ax_neg;
                    y_neg_reg <= ay_neg;
                    cx_reg    <= sx_reg[POS_W-1:FRAC_BITS];
                    cy_reg    <= sy_reg[POS_W-1:FRAC_BITS];
                    steps_reg <= {1'b0, ax_span} + {1'b0, ay_span};
                    state_reg <= ST_MULX;
                end
                ST_MULX: begin
                    state_reg <= ST_MULY;
                end
                ST_MULY: begin
                    px_reg    <= mul_q;
                    state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    py_reg       <= mul_q;
                    m_tvalid_reg <= 1'b1;
                    state_reg    <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (m_tready) begin
                        if (steps_reg == '0) begin
                            m_tvalid_reg <= 1'b0;
                            state_reg    <= ST_IDLE;
                        end else begin
                            steps_reg <= steps_reg - 1'b1;
                            if (step_y) begin
                                cy_reg <= y_neg_reg ? cy_reg - 1'b1 : cy_reg + 1'b1;
                                py_reg <= py_reg + inc_y;
                            end else begin
                                cx_reg <= x_neg_reg ? cx_reg - 1'b1 : cx_reg + 1'b1;
                                px_reg <= px_reg + inc_x;
                            end
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_W-2*GRID_BITS){1'b0}}, cy_reg, cx_reg};
    assign m_tlast  = (steps_reg == '0);

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input accepted while a cell is pending");

    a_last_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("block not idle after last cell");

    a_fixed_x: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && !x_mv_reg) |=> (cx_reg == $past(cx_reg)))
        else $error("x moved on a zero-extent axis");

    a_valid_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (state_reg == ST_EMIT))
        else $error("output valid outside the walk");

endmodule

// ----- tb/tb_grid_ray_cell_walker.sv -----
// Testbench for grid_ray_cell_walker: corner and random segments checked against a cell-walk predictor.
module tb_grid_ray_cell_walker;
    import grcw_pkg::*;

    localparam int GB              = GRID_BITS_DEF;
    localparam int FB              = FRAC_BITS_DEF;
    localparam int POS_W           = GB + FB;
    localparam int S_W             = ((4 * POS_W + 7) / 8) * 8;
    localparam int M_W             = ((2 * GB + 7) / 8) * 8;
    localparam int CELL_RAW        = 1 << FB;
    localparam int POS_MAX         = (1 << POS_W) - 1;
    localparam int RANDOM_SEGMENTS = 270;
    localparam int LIMIT_CYCLES    = 400000;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 20;
    localparam int REPORT_MAX      = 10;

    typedef logic [POS_W-1:0] pos_t;
    typedef logic [GB-1:0]    cell_idx_t;
    typedef struct packed {
        cell_idx_t x;
        cell_idx_t y;
        logic      last;
    } cell_t;

    class cell_scoreboard;
        cell_t     cells_due[$];
        cell_idx_t walk_x;
        cell_idx_t walk_y;
        int        faults;

        function new();
            walk_x = '0;
            walk_y = '0;
            faults = 0;
        endfunction

        // extent, raw distance to the first boundary, direction and cells spanned on one axis
        function void measure_axis(input pos_t s, input pos_t e,
                                   output longint unsigned ext, output longint unsigned num,
                                   output bit neg, output int span);
            ext  = 0;
            num  = 0;
            neg  = 1'b0;
            span = 0;
            if (e > s) begin
                ext  = e - s;
                num  = CELL_RAW - s[FB-1:0];
                span = e[POS_W-1:FB] - s[POS_W-1:FB];
            end else if (e < s) begin
                ext  = s - e;
                num  = s[FB-1:0];
                neg  = 1'b1;
                span = s[POS_W-1:FB] - e[POS_W-1:FB];
            end
        endfunction

        // queue every cell the segment visits, in walk order
        function void note_segment(input pos_t sx, input pos_t sy, input pos_t ex, input pos_t ey);
            longint unsigned dx, dy, nx, ny;
            bit              neg_x, neg_y, go_y;
            int              span_x, span_y, count;
            cell_t           c;
            measure_axis(sx, ex, dx, nx, neg_x, span_x);
            measure_axis(sy, ey, dy, ny, neg_y, span_y);
            walk_x = sx[POS_W-1:FB];
            walk_y = sy[POS_W-1:FB];
            count  = 1 + span_x + span_y;
            for (int k = 0; k < count; k++) begin
                c.x    = walk_x;
                c.y    = walk_y;
                c.last = (k == count - 1);
                cells_due.push_back(c);
                if (!c.last) begin
                    if (dx == 0)
                        go_y = 1'b1;
                    else if (dy == 0)
                        go_y = 1'b0;
                    else
                        go_y = (ny * dx) < (nx * dy);  // ties go to x
                    // cell indices wrap at the grid edge
                    if (go_y) begin
                        walk_y = neg_y ? walk_y - 1'b1 : walk_y + 1'b1;
                        ny += CELL_RAW;
                    end else begin
                        walk_x = neg_x ? walk_x - 1'b1 : walk_x + 1'b1;
                        nx += CELL_RAW;
                    end
                end
            end
        endfunction

        function void check_cell(input cell_idx_t x, input cell_idx_t y, input logic last);
            cell_t want;
            if (cells_due.size() == 0) begin
                faults++;
                if (faults <= REPORT_MAX)
                    $display("unexpected cell: x=%0d y=%0d last=%0d", x, y, last);
                return;
            end
            want = cells_due.pop_front();
            if (want.x !== x || want.y !== y || want.last !== last) begin
                faults++;
                if (faults <= REPORT_MAX)
                    $display("cell mismatch: expected x=%0d y=%0d last=%0d, got x=%0d y=%0d last=%0d",
                             want.x, want.y, want.last, x, y, last);
            end
        endfunction
    endclass

    logic           aclk;
    logic           aresetn;
    logic           s_tvalid;
    logic           s_tready;
    logic [S_W-1:0] s_tdata;
    logic           m_tvalid;
    logic           m_tready;
    logic [M_W-1:0] m_tdata;
    logic           m_tlast;

    cell_scoreboard sb = new();
    bit             steady;       // no idling on either side
    int             hold_ticket;  // bumped to ask the receiver for a long hold-off
    int             cycle_count;

    grid_ray_cell_walker u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // receiver: random backpressure, long hold-off on request
    initial begin
        int hold_left;
        int hold_served;
        hold_left   = 0;
        hold_served = 0;
        m_tready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_ticket != hold_served) begin
                hold_served = hold_ticket;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (steady) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 17);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_cell(m_tdata[GB-1:0], m_tdata[2*GB-1:GB], m_tlast);
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int clamp_pos(input int v);
        return (v < 0) ? 0 : (v > POS_MAX) ? POS_MAX : v;
    endfunction

    // called and returns at a falling edge
    task automatic send_segment(input int sx, input int sy, input int ex, input int ey);
        logic [S_W-1:0] word;
        word = '0;
        word[0*POS_W +: POS_W] = pos_t'(sx);
        word[1*POS_W +: POS_W] = pos_t'(sy);
        word[2*POS_W +: POS_W] = pos_t'(ex);
        word[3*POS_W +: POS_W] = pos_t'(ey);
        if (!steady && $urandom_range(99) < 17) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        sb.note_segment(pos_t'(sx), pos_t'(sy), pos_t'(ex), pos_t'(ey));
        @(negedge aclk);
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (sb.cells_due.size() != 0) @(negedge aclk);
    endtask

    task automatic send_random_segment();
        int style, d, tmp;
        int sx, sy, ex, ey;
        style = $urandom_range(99);
        sx = $urandom_range(POS_MAX);
        sy = $urandom_range(POS_MAX);
        ex = $urandom_range(POS_MAX);
        ey = $urandom_range(POS_MAX);
        if (style < 30) begin
            // short walks
            ex = clamp_pos(sx + int'($urandom_range(6000)) - 3000);
            ey = clamp_pos(sy + int'($urandom_range(6000)) - 3000);
        end else if (style < 45) begin
            // end points on grid lines or mid-cell
            sx = $urandom_range(31) * CELL_RAW + $urandom_range(1) * (CELL_RAW / 2);
            sy = $urandom_range(31) * CELL_RAW + $urandom_range(1) * (CELL_RAW / 2);
            ex = $urandom_range(31) * CELL_RAW + $urandom_range(1) * (CELL_RAW / 2);
            ey = $urandom_range(31) * CELL_RAW + $urandom_range(1) * (CELL_RAW / 2);
        end else if (style < 60) begin
            // exact diagonals hit corners and force ties
            d  = $urandom_range(1, 12) * CELL_RAW;
            sx = $urandom_range(POS_MAX - d);
            sy = $urandom_range(POS_MAX - d);
            if ($urandom_range(1)) begin
                sx = (sx / CELL_RAW) * CELL_RAW;
                sy = (sy / CELL_RAW) * CELL_RAW;
            end
            ex = sx + d;
            ey = sy + d;
            if ($urandom_range(1)) begin
                tmp = sx; sx = ex; ex = tmp;
            end
            if ($urandom_range(1)) begin
                tmp = sy; sy = ey; ey = tmp;
            end
        end else if (style < 70) begin
            if ($urandom_range(1))
                ex = sx;
            else
                ey = sy;
        end
        send_segment(sx, sy, ex, ey);
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        steady      = 1'b0;
        hold_ticket = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // corners of the field ranges and the special walks
        send_segment(0, 0, 0, 0);
        send_segment(POS_MAX, POS_MAX, POS_MAX, POS_MAX);
        send_segment(0, 0, POS_MAX, POS_MAX);
        send_segment(POS_MAX, POS_MAX, 0, 0);
        send_segment(0, POS_MAX, POS_MAX, 0);
        send_segment(POS_MAX, 0, 0, POS_MAX);
        send_segment(100, 5000, 30000, 5000);
        send_segment(7000, 32000, 7000, 10);
        send_segment(1024, 1024, 0, 0);          // both axes start on a line, moving down
        send_segment(3072, 5000, 100, 9000);
        send_segment(512, 512, 2048, 2048);      // corner ties all the way
        send_segment(512, 512, 0, 1024);         // tie at the end steps x below zero
        send_segment(1536, 1536, 0, 0);
        send_segment(700, 600, 900, 800);        // one cell, nonzero extent
        send_segment(16384, 16384, 16385, 16383);
        send_segment(1023, 1023, 1024, 1024);
        send_segment(1024, 2048, 1023, 2047);
        send_segment(21845, 10922, 10922, 21845);

        for (int i = 0; i < RANDOM_SEGMENTS; i++) begin
            if (i == 60) begin
                // receiver stalls while the sender keeps pushing
                hold_ticket++;
                steady = 1'b1;
            end
            if (i == 100)
                steady = 1'b0;
            if (i == 150)
                wait_results_drained();
            if (i == 190)
                steady = 1'b1;
            if (i == 235)
                steady = 1'b0;
            send_random_segment();
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.faults == 0 && sb.cells_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
